[hdl/assert_macros.svh]
// Assertion macros shared by the prime pair counter RTL.
// Clocked property checks with asynchronous active-low reset; empty under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define PPG_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define PPG_ASSERT(lbl, clk, rst_n, prop)
`define PPG_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

[hdl/ppg6_pkg.sv]
`timescale 1ns / 1ps
// Package for the prime pair (gap six) counter: defaults, constants, status type.
// No dependencies.
package ppg6_pkg;

	localparam int VALUE_WIDTH_DEF = 31;
	localparam int COUNT_WIDTH_DEF = 24;

	localparam int FIRST_ODD_DIVISOR = 3;
	localparam int SMALLEST_PRIME    = 3;
	localparam int TARGET_RESET      = 1;

	// status of the shared remainder unit
	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
	} rem_status_t;

endpackage

[hdl/prime_pair_gap6_counter_core.sv]
`timescale 1ns / 1ps
// Top level of the prime pair (gap six) counter: sequencer, pair window, count, output register.
// Depends on ppg6_pkg, ppg6_rem and assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: candidate; tuser: restart, clear_count
//  m_*     | out | m_tvalid/m_tready  | tdata: pairs_so_far, largest_pair_top; tuser: flags
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: target_count
//
// A candidate below 3 or even goes straight to the result. Otherwise each odd
// divisor d >= 3 with d*d <= candidate is tried in turn on the bit-serial remainder
// unit; the first divisor that divides the candidate ends the search, and a candidate
// that no divisor divides is prime.
// Reset clears control, window, count, latched top and sets target to 1.
// s_tready is high only when the sequencer is idle; a finished result waits in
// the output register, and the sequencer stalls on it if m_tready is low.
`include "assert_macros.svh"
module prime_pair_gap6_counter_core #(
	parameter int VALUE_WIDTH = ppg6_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = ppg6_pkg::COUNT_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]      s_tdata,  // candidate
	input  logic [1:0]                            s_tuser,  // restart, clear_count
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// pairs_so_far, largest_pair_top
	output logic [((VALUE_WIDTH+COUNT_WIDTH+7)/8)*8-1:0] m_tdata,
	output logic [2:0]                            m_tuser,  // prime, pair_found, target_reached
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [COUNT_WIDTH-1:0]                cfg_data  // target_count
);

	localparam int OUT_W = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
	localparam int SQ_W  = VALUE_WIDTH + 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]             state_q;
	logic [VALUE_WIDTH-1:0] cand_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [SQ_W-1:0]        sq_q;
	logic                   prime_q;
	logic [2:0]             window_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [VALUE_WIDTH-1:0] top_q;
	logic [COUNT_WIDTH-1:0] target_q;
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;
	logic [2:0]             m_tuser_q;

	logic [VALUE_WIDTH-1:0] s_cand;
	logic                   s_acc;
	logic                   sq_over;
	logic                   rem_start;
	logic                   out_free;
	logic                   counted;
	logic [COUNT_WIDTH-1:0] count_next;
	logic [VALUE_WIDTH-1:0] top_next;
	logic                   reached;
	ppg6_pkg::rem_status_t  rem_st;

	assign s_cand    = s_tdata[VALUE_WIDTH-1:0];
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign sq_over   = (sq_q > {1'b0, cand_q});
	assign rem_start = (state_q == ST_CHECK) && !sq_over;

	ppg6_rem #(
		.W(VALUE_WIDTH)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(cand_q),
		.divisor (d_q),
		.status  (rem_st)
	);

	always_comb begin
		counted    = prime_q && window_q[2] && (count_q < target_q);
		count_next = counted ? count_q + COUNT_WIDTH'(1) : count_q;
		top_next   = counted ? cand_q : top_q;
		reached    = (count_next >= target_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			window_q   <= '0;
			count_q    <= '0;
			top_q      <= '0;
			target_q   <= COUNT_WIDTH'(ppg6_pkg::TARGET_RESET);
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				target_q <= cfg_data;
			end
			// a finished item fills the output register when it is empty or as the old transaction leaves
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser[0]) begin
							window_q <= '0;
						end
						if (s_tuser[1]) begin
							count_q <= '0;
							top_q   <= '0;
						end
						if (s_cand < VALUE_WIDTH'(ppg6_pkg::SMALLEST_PRIME) || !s_cand[0]) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					// no divisor up to the root: prime
					state_q <= sq_over ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (rem_st.done) begin
						state_q <= rem_st.zero ? ST_DONE : ST_CHECK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						window_q   <= {window_q[1:0], prime_q};
						count_q    <= count_next;
						top_q      <= top_next;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (s_acc) begin
			cand_q  <= s_cand;
			d_q     <= VALUE_WIDTH'(ppg6_pkg::FIRST_ODD_DIVISOR);
			sq_q    <= SQ_W'(ppg6_pkg::FIRST_ODD_DIVISOR * ppg6_pkg::FIRST_ODD_DIVISOR);
			prime_q <= !(s_cand < VALUE_WIDTH'(ppg6_pkg::SMALLEST_PRIME) || !s_cand[0]);
		end else if (state_q == ST_DIV && rem_st.done) begin
			if (rem_st.zero) begin
				prime_q <= 1'b0;
			end
			// (d+2)^2 = d^2 + 4(d+1)
			d_q  <= d_q + VALUE_WIDTH'(2);
			sq_q <= sq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
		end
		if (state_q == ST_DONE && out_free) begin
			m_tdata_q <= OUT_W'({top_next, count_next});
			m_tuser_q <= {reached, counted, prime_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`PPG_ASSERT(a_ready_unit_idle, clk, arst_n, s_tready |-> !rem_st.busy)
	`PPG_ASSERT(a_done_in_div, clk, arst_n, rem_st.done |-> (state_q == ST_DIV))
	`PPG_ASSERT(a_pair_is_prime, clk, arst_n, (m_tvalid && m_tuser[1]) |-> m_tuser[0])
	`PPG_ASSERT(a_accept_leaves_idle, clk, arst_n, s_acc |=> !s_tready)
	`PPG_NEVER(a_even_prime, clk, arst_n, (state_q == ST_DONE) && prime_q && !cand_q[0])

endmodule

[hdl/ppg6_rem.sv]
`timescale 1ns / 1ps
// Bit-serial remainder unit: one compare/subtract step per cycle, W steps per remainder.
// Depends on ppg6_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ppg6_rem #(
	parameter int W = ppg6_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [W-1:0]         dividend,
	input  logic [W-1:0]         divisor,
	output ppg6_pkg::rem_status_t status
);

	localparam int CNT_W = $clog2(W);

	logic [W:0]       rem_q;
	logic [W-1:0]     dvd_q;
	logic [W-1:0]     div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [W:0] trial;
	logic [W:0] rem_next;

	always_comb begin
		trial = {rem_q[W-1:0], dvd_q[W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = trial - {1'b0, div_q};
		end else begin
			rem_next = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[W-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign status.zero = (rem_q == '0);

	`PPG_ASSERT(a_start_idle, clk, arst_n, start |-> !busy_q)
	`PPG_ASSERT(a_done_not_busy, clk, arst_n, done_q |-> !busy_q)
	`PPG_ASSERT(a_done_after_busy, clk, arst_n, done_q |-> $past(busy_q))

endmodule
